FILE: design/sjis_vertical_mode_escape_inserter_assert.svh
// assertion macros used by the checker file of the escape inserter
`ifndef SJIS_VERTICAL_MODE_ESCAPE_INSERTER_ASSERT_SVH
`define SJIS_VERTICAL_MODE_ESCAPE_INSERTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SVMEI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escape inserter check failed");

// next-cycle implication, disabled during reset
`define SVMEI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape inserter check failed");

`endif

FILE: design/svmei_pkg.sv
// shared types, constants and functions of the vertical-mode escape inserter
package svmei_pkg;

  localparam int unsigned ESC_LEN = 6;
  localparam int unsigned IDX_W   = 3;
  localparam logic [IDX_W-1:0] IDX_TEXT = IDX_W'(ESC_LEN);

  localparam logic [7:0] FONT_VERT_A = 8'd6;
  localparam logic [7:0] FONT_VERT_B = 8'd8;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_ON   = 2'd1,
    ESC_OFF  = 2'd2
  } esc_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] font_id;
    logic       start_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  function automatic logic is_lead_byte(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  // byte idx of the vertical on/off escape; the two differ only in the last byte
  function automatic logic [7:0] esc_byte(input esc_kind_t kind,
                                          input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd0: b = 8'h1B;
      3'd1: b = 8'h7E;
      3'd2: b = 8'h0E;
      3'd3: b = 8'h00;
      3'd4: b = 8'h01;
      3'd5: b = (kind == ESC_ON) ? 8'h0B : 8'h0C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/sjis_vertical_mode_escape_inserter.sv
// top level of the shift-jis vertical-mode escape inserter
// a request is registered in stage a, then in stage b, which drives the result byte;
//   stage a holds it while stage b is still busy with an earlier request
// throughput: one request per cycle for plain text while the result is not stalled;
//   an escaped request holds the output sequencer for six escape bytes, then text
// the two request registers let a new request in while a result waits to be taken
// reset: rst is synchronous, active high; clears both stages and returns to
//   double-byte mode with no trail byte expected
module sjis_vertical_mode_escape_inserter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  svmei_pkg::in_t    req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output svmei_pkg::out_t   rsp
);

  // text mode tracking, updated as each request is accepted
  logic double_byte_mode;
  logic double_byte_mode_next;
  logic trail_expected;
  logic trail_expected_next;

  // stage a: decoded request
  logic                 a_valid;
  logic [7:0]           a_data;
  svmei_pkg::esc_kind_t a_kind;

  // stage b: output sequencer walking escape bytes then the text byte
  logic                               b_valid;
  logic [7:0]                         b_data;
  svmei_pkg::esc_kind_t               b_kind;
  logic [svmei_pkg::IDX_W-1:0]        b_idx;

  svmei_pkg::esc_kind_t kind_next;
  logic                 req_take;
  logic                 rsp_take;
  logic                 b_last;
  logic                 b_load;

  // decide the escape for the incoming byte from the mode it sees
  always_comb begin
    logic mode_in;
    logic trail_in;
    mode_in  = req.start_of_string ? 1'b1 : double_byte_mode;
    trail_in = req.start_of_string ? 1'b0 : trail_expected;
    kind_next             = svmei_pkg::ESC_NONE;
    double_byte_mode_next = mode_in;
    trail_expected_next   = trail_in;
    if (req.font_id == svmei_pkg::FONT_VERT_A || req.font_id == svmei_pkg::FONT_VERT_B) begin
      if (trail_in) begin
        // trail byte of a double-byte character passes as is
        trail_expected_next = 1'b0;
      end else if (svmei_pkg::is_lead_byte(req.data_byte)) begin
        if (!mode_in) begin
          kind_next             = svmei_pkg::ESC_ON;
          double_byte_mode_next = 1'b1;
        end
        trail_expected_next = 1'b1;
      end else begin
        if (mode_in) begin
          kind_next             = svmei_pkg::ESC_OFF;
          double_byte_mode_next = 1'b0;
        end
      end
    end
  end

  // handshake between the stages
  assign b_last    = (b_idx == svmei_pkg::IDX_TEXT);
  assign rsp_take  = b_valid && !rsp_stall;
  assign b_load    = a_valid && (!b_valid || (rsp_take && b_last));
  assign req_stall = a_valid && !b_load;
  assign req_take  = req_valid && !req_stall;

  // mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      double_byte_mode <= 1'b1;
      trail_expected   <= 1'b0;
    end else if (req_take) begin
      double_byte_mode <= double_byte_mode_next;
      trail_expected   <= trail_expected_next;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_take) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      a_data <= req.data_byte;
      a_kind <= kind_next;
    end
  end

  // stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (rsp_take && b_last) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_data <= a_data;
      b_kind <= a_kind;
      // no escape: start straight at the text byte
      b_idx  <= (a_kind == svmei_pkg::ESC_NONE) ? svmei_pkg::IDX_TEXT
                                                : '0;
    end else if (rsp_take && !b_last) begin
      b_idx <= b_idx + 1'b1;
    end
  end

  // result byte is a small mux of registered stage b state
  assign rsp_valid       = b_valid;
  assign rsp.out_byte    = b_last ? b_data : svmei_pkg::esc_byte(b_kind, b_idx);
  assign rsp.last_of_run = b_last;

endmodule

FILE: design/svmei_checker.sv
// port-level checker for the escape inserter, bound to the top level
`include "sjis_vertical_mode_escape_inserter_assert.svh"

module svmei_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input svmei_pkg::out_t rsp
);

  logic rsp_take;
  assign rsp_take = rsp_valid && !rsp_stall;

  // a stalled result holds
  `SVMEI_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // an escape run never breaks off before its text byte
  `SVMEI_ASSERT_NEXT(a_run_cont, clk, rst, rsp_take && !rsp.last_of_run, rsp_valid)

  // an escape starts with its two-byte prefix
  `SVMEI_ASSERT_NEXT(a_esc_prefix, clk, rst,
    rsp_take && !rsp.last_of_run && rsp.out_byte == 8'h1B, rsp.out_byte == 8'h7E)

  // the mode byte ends the escape; the text byte follows
  `SVMEI_ASSERT_NEXT(a_esc_end, clk, rst,
    rsp_take && !rsp.last_of_run && (rsp.out_byte == 8'h0B || rsp.out_byte == 8'h0C),
    rsp_valid && rsp.last_of_run)

  // idle stage b cannot stall requests with an empty input stage
  `SVMEI_ASSERT_NOW(a_req_free, clk, rst, !rsp_valid && $past(!req_valid) && !rst && $past(!rst),
    !req_stall)

endmodule

bind sjis_vertical_mode_escape_inserter svmei_checker u_svmei_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: dv/sjis_vertical_mode_escape_inserter_tb.sv
// testbench for the shift-jis vertical-mode escape inserter: directed table, random strings, scoreboard
module sjis_vertical_mode_escape_inserter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQS    = 190;
  localparam int unsigned STALL_PCT      = 16;   // idle / stall odds per cycle, in percent
  localparam int unsigned RX_HOLD_CYCLES = 200;  // long receiver hold-off to fill the block
  localparam int unsigned IDLE_LIMIT     = 2000; // watchdog: cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES   = 12;   // settle time after the last result
  localparam int unsigned MAX_REPORTS    = 10;

  // random-part milestones, counted in requests
  localparam int unsigned CALM_FIRST = 40;
  localparam int unsigned CALM_LAST  = 90;
  localparam int unsigned HOLD_AT    = 100;
  localparam int unsigned PAUSE_AT   = 150;

  // vertical escapes share five bytes and differ in the last one
  localparam logic [39:0] ESC_PREFIX   = 40'h1B_7E_0E_00_01;
  localparam logic [7:0]  ESC_ON_TAIL  = 8'h0B;
  localparam logic [7:0]  ESC_OFF_TAIL = 8'h0C;

  // how a stimulus row is checked: by the predictor, or by the escape typed into the table
  typedef enum logic [1:0] {
    ROW_MODEL = 2'd0,
    ROW_PLAIN = 2'd1,
    ROW_ON    = 2'd2,
    ROW_OFF   = 2'd3
  } row_check_t;

  typedef struct packed {
    svmei_pkg::in_t item;
    row_check_t     chk;
  } stim_row_t;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  svmei_pkg::in_t  req       = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  svmei_pkg::out_t rsp;

  sjis_vertical_mode_escape_inserter uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // predictor state: text mode and pending trail byte
  logic dbcs_mode     = 1'b1;
  logic trail_pending = 1'b0;

  svmei_pkg::out_t expected_bytes[$];  // result bytes still owed by the block, oldest first
  row_check_t      row_checks[$];      // check kind of each offered request, in order
  stim_row_t       directed_rows[$];

  int unsigned fail_count    = 0;
  int unsigned reqs_accepted = 0;
  int unsigned bytes_checked = 0;
  int unsigned on_escapes    = 0;
  int unsigned off_escapes   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned n_directed    = 0;
  bit          calm          = 1'b0;  // no idling or stalling on either side
  bit          rx_hold_req   = 1'b0;  // asks the receiver for one long hold-off

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic sjis_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  // advances the mode tracker by one request and says which escape goes before the byte
  function automatic svmei_pkg::esc_kind_t mode_switch_for(input svmei_pkg::in_t r);
    svmei_pkg::esc_kind_t kind;
    kind = svmei_pkg::ESC_NONE;
    // a new string starts in double-byte mode and forgets a dangling lead byte
    if (r.start_of_string) begin
      dbcs_mode     = 1'b1;
      trail_pending = 1'b0;
    end
    // other fonts pass straight through and leave the mode alone
    if (r.font_id != svmei_pkg::FONT_VERT_A && r.font_id != svmei_pkg::FONT_VERT_B)
      return kind;
    // the byte after a lead byte is its trail, whatever its value
    if (trail_pending) begin
      trail_pending = 1'b0;
      return kind;
    end
    if (sjis_lead(r.data_byte)) begin
      if (!dbcs_mode) begin
        kind      = svmei_pkg::ESC_ON;
        dbcs_mode = 1'b1;
      end
      trail_pending = 1'b1;
    end else if (dbcs_mode) begin
      // 0x80, 0xa0-0xdf and 0xfd-0xff land here as single-byte text too
      kind      = svmei_pkg::ESC_OFF;
      dbcs_mode = 1'b0;
    end
    return kind;
  endfunction

  // queues the escape (if any) and the text byte, marking the last one of the run
  function automatic void owe_bytes(input svmei_pkg::esc_kind_t kind,
                                    input logic [7:0] text);
    svmei_pkg::out_t o;
    int              i;
    if (kind != svmei_pkg::ESC_NONE) begin
      for (i = 0; i < 6; i++) begin
        o.out_byte    = (i < 5) ? ESC_PREFIX[39 - 8*i -: 8]
                                : ((kind == svmei_pkg::ESC_ON) ? ESC_ON_TAIL : ESC_OFF_TAIL);
        o.last_of_run = 1'b0;
        expected_bytes.push_back(o);
      end
    end
    o.out_byte    = text;
    o.last_of_run = 1'b1;
    expected_bytes.push_back(o);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s", $realtime, msg);
  endfunction

  // scoreboard: predict on each accepted request, compare each accepted result byte
  always @(posedge clk) begin : scoreboard
    row_check_t           chk;
    svmei_pkg::esc_kind_t kind;
    svmei_pkg::out_t      want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        chk  = row_checks.pop_front();
        kind = mode_switch_for(req);
        // typed rows carry their own answer; the predictor still tracks the mode
        case (chk)
          ROW_PLAIN: kind = svmei_pkg::ESC_NONE;
          ROW_ON:    kind = svmei_pkg::ESC_ON;
          ROW_OFF:   kind = svmei_pkg::ESC_OFF;
          default:   ;
        endcase
        if (kind == svmei_pkg::ESC_ON)
          on_escapes++;
        if (kind == svmei_pkg::ESC_OFF)
          off_escapes++;
        owe_bytes(kind, req.data_byte);
        reqs_accepted++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_bytes.size() == 0) begin
          note_failure($sformatf("unexpected result byte %02h last %0b",
                                 rsp.out_byte, rsp.last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (rsp.out_byte !== want.out_byte || rsp.last_of_run !== want.last_of_run)
            note_failure($sformatf("result byte %0d: expected %02h last %0b, got %02h last %0b",
                                   bytes_checked, want.out_byte, want.last_of_run,
                                   rsp.out_byte, rsp.last_of_run));
        end
      end
    end
  end

  // watchdog: gives up when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d bytes still owed",
               IDLE_LIMIT, expected_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, a calm stretch, and one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= !calm && ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  function automatic void add_row(input logic [7:0] d, input logic [7:0] f,
                                  input logic s, input row_check_t c);
    stim_row_t r;
    r.item.data_byte       = d;
    r.item.font_id         = f;
    r.item.start_of_string = s;
    r.chk                  = c;
    directed_rows.push_back(r);
  endfunction

  // mostly vertical-font bytes from the lead, ascii and katakana ranges, some noise
  function automatic stim_row_t random_row();
    stim_row_t   r;
    int unsigned pick;
    r.chk                  = ROW_MODEL;
    r.item.start_of_string = ($urandom_range(99) < 8);
    pick = $urandom_range(99);
    if (pick < 70)
      r.item.font_id = $urandom_range(1) ? svmei_pkg::FONT_VERT_A : svmei_pkg::FONT_VERT_B;
    else if (pick < 80)
      r.item.font_id = 8'($urandom_range(9, 5));
    else
      r.item.font_id = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25)
      r.item.data_byte = 8'($urandom_range(8'h9F, 8'h81));
    else if (pick < 40)
      r.item.data_byte = 8'($urandom_range(8'hFC, 8'hE0));
    else if (pick < 60)
      r.item.data_byte = 8'($urandom_range(8'h7F, 8'h00));
    else if (pick < 80)
      r.item.data_byte = 8'($urandom_range(8'hDF, 8'hA0));
    else
      r.item.data_byte = 8'($urandom_range(255));
    return r;
  endfunction

  // offers one request, with random idle cycles first, and returns once it is taken
  task automatic offer(input stim_row_t row);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    row_checks.push_back(row.chk);
    req       <= row.item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  initial begin : stimulus
    stim_row_t   row;
    int unsigned n;

    // directed table; the state after each row follows from the rows above it
    add_row(8'h41, svmei_pkg::FONT_VERT_A, 1'b1, ROW_OFF);    // single byte out of reset
    add_row(8'h81, svmei_pkg::FONT_VERT_A, 1'b0, ROW_ON);     // lowest lead byte after text
    add_row(8'h00, svmei_pkg::FONT_VERT_A, 1'b0, ROW_PLAIN);  // trail byte, smallest value
    add_row(8'hFC, svmei_pkg::FONT_VERT_B, 1'b0, ROW_MODEL);  // highest lead, double-byte
    add_row(8'hFF, svmei_pkg::FONT_VERT_B, 1'b0, ROW_PLAIN);  // trail byte, largest value
    add_row(8'h80, svmei_pkg::FONT_VERT_B, 1'b0, ROW_OFF);    // 0x80 is single-byte
    add_row(8'h9F, svmei_pkg::FONT_VERT_A, 1'b0, ROW_ON);     // top of the low lead range
    add_row(8'hA0, svmei_pkg::FONT_VERT_A, 1'b0, ROW_PLAIN);  // trail that looks single-byte
    add_row(8'hA0, svmei_pkg::FONT_VERT_A, 1'b0, ROW_OFF);    // half-width katakana, bottom
    add_row(8'hDF, svmei_pkg::FONT_VERT_A, 1'b0, ROW_PLAIN);  // half-width katakana, top
    add_row(8'hE0, svmei_pkg::FONT_VERT_A, 1'b0, ROW_ON);     // bottom of the high lead range
    add_row(8'hE0, 8'd7,                   1'b0, ROW_MODEL);  // other font, trail still owed
    add_row(8'h20, svmei_pkg::FONT_VERT_A, 1'b0, ROW_PLAIN);  // the owed trail
    add_row(8'hFD, svmei_pkg::FONT_VERT_A, 1'b0, ROW_OFF);    // above the lead range
    add_row(8'hFE, 8'd0,                   1'b0, ROW_PLAIN);  // font id zero
    add_row(8'h85, 8'd255,                 1'b0, ROW_MODEL);  // font id all ones
    add_row(8'h85, svmei_pkg::FONT_VERT_A, 1'b1, ROW_PLAIN);  // new string, double-byte mode
    add_row(8'h41, svmei_pkg::FONT_VERT_A, 1'b1, ROW_OFF);    // new string drops dangling lead
    add_row(8'hFF, svmei_pkg::FONT_VERT_B, 1'b1, ROW_OFF);    // new string after single-byte
    add_row(8'h00, svmei_pkg::FONT_VERT_B, 1'b0, ROW_MODEL);
    add_row(8'h81, 8'd5,                   1'b1, ROW_PLAIN);  // new string on another font
    add_row(8'h7F, svmei_pkg::FONT_VERT_A, 1'b0, ROW_OFF);    // so text needs vertical off
    add_row(8'h30, 8'd9,                   1'b0, ROW_MODEL);
    n_directed = directed_rows.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer(directed_rows[i]);

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == CALM_FIRST)
        calm = 1'b1;
      if (n == CALM_LAST)
        calm = 1'b0;
      // receiver goes quiet while requests keep coming, so the input backs up
      if (n == HOLD_AT)
        rx_hold_req = 1'b1;
      // sender waits here until every owed byte has come out
      if (n == PAUSE_AT) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
      end
      row = random_row();
      offer(row);
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests (%0d from the table), %0d result bytes compared",
             reqs_accepted, n_directed, bytes_checked);
    $display("run: %0d vertical-on and %0d vertical-off escapes, %0d failures",
             on_escapes, off_escapes, fail_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sjis_vertical_mode_escape_inserter.f
+incdir+design
design/svmei_pkg.sv
design/sjis_vertical_mode_escape_inserter.sv
design/svmei_checker.sv
dv/sjis_vertical_mode_escape_inserter_tb.sv
